### design/mft_pkg.sv
package mft_pkg;

    // field widths
    localparam int T0_W   = 20;
    localparam int VEL_W  = 16;
    localparam int OFF_W  = 17;
    localparam int MAG_W  = 16;
    localparam int TIME_W = 24;

    // internal widths
    localparam int SQ2_W  = 2 * MAG_W;
    localparam int POW_W  = 2 * SQ2_W;
    localparam int T0SQ_W = 2 * T0_W;
    localparam int QBITS  = 50;
    localparam int TERM_W = QBITS;
    localparam int ARG_W  = 2 * TIME_W;
    localparam int SUM_W  = TERM_W + 1;

    // default fraction bits of the time fields
    localparam int TIME_FRAC_BITS_DEF = 16;

    // offset term cap, minimum divisor and offset magnitude bounds
    localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << (QBITS - 1);
    localparam logic [POW_W-1:0]  DEN_MIN  = POW_W'(100);
    localparam logic [MAG_W-1:0]  MAG_MAX  = '1;
    localparam logic [MAG_W-1:0]  MAG_MIN  = MAG_W'(1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_NEGATIVE   = 1'b1;

    // sideband carried through the divider and root pipelines
    typedef struct packed {
        logic [T0SQ_W-1:0] t0sq;
        logic              last;
    } div_side_t;

    typedef struct packed {
        logic sat;
        logic last;
    } sqrt_side_t;

endpackage

### design/mft_divider.sv
module mft_divider #(
    parameter int SQ = 2 * mft_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [mft_pkg::POW_W-1:0]     in_num,
    input  logic [mft_pkg::POW_W-1:0]     in_den,
    input  mft_pkg::div_side_t            in_side,
    output logic                          out_valid,
    output logic [mft_pkg::TERM_W-1:0]    out_term,
    output mft_pkg::div_side_t            out_side
);
    import mft_pkg::*;

    localparam int SHIFT = QBITS - SQ;

    logic [QBITS:0]     valid_reg;
    logic [POW_W-1:0]   rem_reg  [QBITS+1];
    logic [POW_W-1:0]   den_reg  [QBITS+1];
    logic [POW_W-1:0]   num_reg  [QBITS+1];
    logic [QBITS-1:0]   quo_reg  [QBITS+1];
    logic               cap_reg  [QBITS+1];
    div_side_t          side_reg [QBITS+1];

    logic [POW_W-1:0] den_next;
    logic [POW_W-1:0] rem0_next;

    // setup: divisor floor, leading remainder and overflow cap
    always_comb begin
        den_next  = (in_den < DEN_MIN) ? DEN_MIN : in_den;
        rem0_next = in_num >> SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= rem0_next;
            den_reg[0]  <= den_next;
            num_reg[0]  <= in_num;
            quo_reg[0]  <= '0;
            cap_reg[0]  <= (rem0_next >= den_next);
            side_reg[0] <= in_side;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        localparam int J = QBITS - k;
        logic             nbit;
        logic [POW_W:0]   trial;
        logic             ge;
        logic [POW_W:0]   diff;

        if (J >= SQ) begin : g_bit
            assign nbit = num_reg[k-1][J-SQ];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        always_comb begin
            trial = {rem_reg[k-1], nbit};
            ge    = (trial >= {1'b0, den_reg[k-1]});
            diff  = trial - {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= ge ? diff[POW_W-1:0] : trial[POW_W-1:0];
                den_reg[k]  <= den_reg[k-1];
                num_reg[k]  <= num_reg[k-1];
                quo_reg[k]  <= {quo_reg[k-1][QBITS-2:0], ge};
                cap_reg[k]  <= cap_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QBITS];
    assign out_term  = cap_reg[QBITS] ? TERM_CAP : quo_reg[QBITS];
    assign out_side  = side_reg[QBITS];

    // remainder stays below the divisor when no overflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[QBITS] && !cap_reg[QBITS] |-> rem_reg[QBITS] < den_reg[QBITS])
        else $error("divider remainder not below divisor");

    // divisor never under the floor
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] |-> den_reg[0] >= DEN_MIN)
        else $error("divisor below floor");

endmodule

### design/mft_sqrt.sv
module mft_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [mft_pkg::ARG_W-1:0]     in_arg,
    input  mft_pkg::sqrt_side_t           in_side,
    output logic                          out_valid,
    output logic [mft_pkg::TIME_W-1:0]    out_root,
    output mft_pkg::sqrt_side_t           out_side
);
    import mft_pkg::*;

    localparam int REM_W = TIME_W + 2;

    logic [TIME_W-1:0]  valid_reg;
    logic [ARG_W-1:0]   arg_reg  [TIME_W];
    logic [REM_W-1:0]   rem_reg  [TIME_W];
    logic [TIME_W-1:0]  root_reg [TIME_W];
    sqrt_side_t         side_reg [TIME_W];

    // one root bit per stage, two argument bits brought down each time
    for (genvar k = 0; k < TIME_W; k++) begin : g_step
        logic [ARG_W-1:0]  arg_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [TIME_W-1:0] root_prev;
        sqrt_side_t        side_prev;
        logic              valid_prev;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W+1:0]  diff;

        if (k == 0) begin : g_first
            assign arg_prev   = in_arg;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_rest
            assign arg_prev   = arg_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        always_comb begin
            rem_sh = {rem_prev, arg_prev[ARG_W-1-2*k -: 2]};
            trial  = {2'b00, root_prev, 2'b01};
            ge     = (rem_sh >= trial);
            diff   = rem_sh - trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                arg_reg[k]  <= arg_prev;
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg[k] <= {root_prev[TIME_W-2:0], ge};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[TIME_W-1];
    assign out_root  = root_reg[TIME_W-1];
    assign out_side  = side_reg[TIME_W-1];

    // floor root leaves a remainder of at most twice the root
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[TIME_W-1] |->
            {1'b0, rem_reg[TIME_W-1]} <= {2'b00, root_reg[TIME_W-1], 1'b0})
        else $error("root remainder out of range");

endmodule

### design/moveout_time_from_offset.sv
// Nonhyperbolic moveout time t = sqrt(t0^2 + s*|x|^n / max(v^n,100)), one offset per beat.
// The block takes one beat per clock and returns one result beat per input beat, in order;
// stages a, b and c form |x|, the squares and the fourth powers, a 51-stage restoring
// divider gives the offset term after a setup stage, one quotient bit per stage, stage d
// adds the term to t0^2 or subtracts it and flags saturation, and a 24-stage square root
// gives one time bit per stage. A held result stalls the whole pipeline and drops s_ready.
// exponent_select (index 0) picks power two or four, sign_negative (index 1) subtracts the
// term; the user must write both only while the block is empty, which it does not enforce.
module moveout_time_from_offset #(
    parameter int TIME_FRAC_BITS = mft_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                               cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mft_pkg::T0_W-1:0]           s_zero_offset_time,
    input  logic [mft_pkg::VEL_W-1:0]          s_nmo_velocity,
    input  logic signed [mft_pkg::OFF_W-1:0]   s_offset_distance,
    input  logic                               s_last_offset,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mft_pkg::TIME_W-1:0]         m_moveout_time,
    output logic                               m_saturated,
    output logic                               m_last
);
    import mft_pkg::*;

    localparam int SQ = 2 * TIME_FRAC_BITS;

    logic adv;
    logic exponent_select_reg;
    logic sign_negative_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_select_reg <= 1'b0;
            sign_negative_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EXPONENT_SELECT: exponent_select_reg <= cfg_data;
                REG_SIGN_NEGATIVE:   sign_negative_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a result is held
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // stage a: offset magnitude
    logic [OFF_W-1:0] mag_full;
    logic [MAG_W-1:0] mag_next;
    logic             a_valid_reg;
    logic [MAG_W-1:0] a_mag_reg;
    logic [T0_W-1:0]  a_t0_reg;
    logic [VEL_W-1:0] a_vel_reg;
    logic             a_last_reg;

    always_comb begin
        mag_full = s_offset_distance[OFF_W-1] ? (-s_offset_distance) : s_offset_distance;
        if (mag_full[OFF_W-1]) begin
            mag_next = MAG_MAX;
        end else if (mag_full[MAG_W-1:0] == '0) begin
            mag_next = MAG_MIN;
        end else begin
            mag_next = mag_full[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_mag_reg  <= mag_next;
            a_t0_reg   <= s_zero_offset_time;
            a_vel_reg  <= s_nmo_velocity;
            a_last_reg <= s_last_offset;
        end
    end

    // stage b: squares
    logic              b_valid_reg;
    logic [SQ2_W-1:0]  b_x2_reg;
    logic [SQ2_W-1:0]  b_v2_reg;
    logic [T0SQ_W-1:0] b_t0sq_reg;
    logic              b_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_x2_reg   <= SQ2_W'(a_mag_reg) * SQ2_W'(a_mag_reg);
            b_v2_reg   <= SQ2_W'(a_vel_reg) * SQ2_W'(a_vel_reg);
            b_t0sq_reg <= T0SQ_W'(a_t0_reg) * T0SQ_W'(a_t0_reg);
            b_last_reg <= a_last_reg;
        end
    end

    // stage c: fourth powers when selected
    logic              c_valid_reg;
    logic [POW_W-1:0]  c_xn_reg;
    logic [POW_W-1:0]  c_vn_reg;
    div_side_t         c_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_xn_reg <= exponent_select_reg ? POW_W'(b_x2_reg) * POW_W'(b_x2_reg)
                                            : POW_W'(b_x2_reg);
            c_vn_reg <= exponent_select_reg ? POW_W'(b_v2_reg) * POW_W'(b_v2_reg)
                                            : POW_W'(b_v2_reg);
            c_side_reg.t0sq <= b_t0sq_reg;
            c_side_reg.last <= b_last_reg;
        end
    end

    // offset term
    logic              div_valid;
    logic [TERM_W-1:0] div_term;
    div_side_t         div_side;

    mft_divider #(
        .SQ(SQ)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (c_valid_reg),
        .in_num    (c_xn_reg),
        .in_den    (c_vn_reg),
        .in_side   (c_side_reg),
        .out_valid (div_valid),
        .out_term  (div_term),
        .out_side  (div_side)
    );

    // stage d: root argument and saturation
    logic [SUM_W-1:0] t0sq_ext;
    logic [SUM_W-1:0] term_ext;
    logic [SUM_W-1:0] arg_next;
    logic             sat_next;
    logic             d_valid_reg;
    logic [ARG_W-1:0] d_arg_reg;
    sqrt_side_t       d_side_reg;

    always_comb begin
        t0sq_ext = SUM_W'(div_side.t0sq);
        term_ext = SUM_W'(div_term);
        if (sign_negative_reg) begin
            arg_next = (term_ext >= t0sq_ext) ? '0 : (t0sq_ext - term_ext);
        end else begin
            arg_next = t0sq_ext + term_ext;
        end
        sat_next = |arg_next[SUM_W-1:ARG_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_arg_reg       <= sat_next ? '0 : arg_next[ARG_W-1:0];
            d_side_reg.sat  <= sat_next;
            d_side_reg.last <= div_side.last;
        end
    end

    // square root, last stage is the output register
    logic [TIME_W-1:0] sqrt_root;
    sqrt_side_t        sqrt_side;

    mft_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_valid_reg),
        .in_arg    (d_arg_reg),
        .in_side   (d_side_reg),
        .out_valid (m_valid),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    assign m_moveout_time = sqrt_side.sat ? '1 : sqrt_root;
    assign m_saturated    = sqrt_side.sat;
    assign m_last         = sqrt_side.last;

    // saturated result is full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_moveout_time == {TIME_W{1'b1}})
        else $error("saturated beat not at full scale");

    // subtraction never saturates
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_valid && sign_negative_reg |-> !sat_next)
        else $error("difference flagged as saturated");

    // input stalls only behind a held result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without held result");

endmodule
